// ----- rtl/fcm_pkg.sv -----
// Shared types, codes and constants for the chain manager.
// Used by fcm_ctrl, fcm_datapath and fat_chain_manager; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcm_pkg;

  localparam int IDX_W   = 12;
  localparam int LINK_W  = 13;
  localparam int BYTES_W = 25;
  localparam int CNT_W   = 14;
  localparam int K_W     = 13;
  localparam int BLK_SH  = 12;
  localparam int ENTRIES = 4096;

  localparam logic [LINK_W-1:0] MARK_FREE = 13'h1FFE;
  localparam logic [LINK_W-1:0] MARK_END  = 13'h1FFF;
  localparam logic [K_W-1:0]    ENTRIES_K = 13'd4096;
  localparam logic [K_W-1:0]    BIU_RESET = 13'd4096;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_RESIZE = 2'd2;
  localparam logic [1:0] MODE_WALK   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PARTIAL = 2'd1;
  localparam logic [1:0] ST_BEYOND  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [IDX_W-1:0]   start_block;
    logic [BYTES_W-1:0] current_size;
    logic [BYTES_W-1:0] length_bytes;
    logic [BYTES_W-1:0] file_pointer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   block_index;
    logic [BYTES_W-1:0] size_bytes;
    logic [BYTES_W-1:0] pointer_bytes;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_SCAN_RD, OP_SCAN_NX, OP_CREATE_OK, OP_CREATE_FAIL,
    OP_RD_BLK, OP_FR_STEP, OP_ADV, OP_G_MARK, OP_G_LINK, OP_G_NEW, OP_WR_END,
    OP_S_LAST_CHK, OP_RD_E, OP_SF_STEP, OP_SF_DONE, OP_FIN, OP_WALK_INIT,
    OP_FO_STEP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       len_gt_cur;
    logic       scan_end;
    logic       is_free;
    logic       rd_mark;
    logic       cnt_lt_new;
    logic       cnt_lt_old;
    logic       e_mark;
    logic       follow_done;
    logic       free_lim;
    logic       out_free;
    logic       clr_done;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] chain_blocks(input logic [BYTES_W-1:0] b);
    logic [BYTES_W-1:0] m;
    m = b - 25'd1;
    if (b == '0) return 14'd1;
    return CNT_W'(m >> BLK_SH) + 14'd1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fcm_datapath.sv -----
// Datapath: link table memory, request registers, counters and output register.
// Executes fcm_pkg::dp_op_t commands from fcm_ctrl; depends on fcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcm_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  fcm_pkg::dp_op_t     op,
  input  fcm_pkg::in_item_t   in_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [12:0]         cfg_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output fcm_pkg::out_item_t  out_data,
  output fcm_pkg::dp_status_t st
);

  logic [fcm_pkg::LINK_W-1:0] mem [fcm_pkg::ENTRIES];

  logic [fcm_pkg::K_W-1:0]     biu_r;
  logic [1:0]                  mode_r;
  logic [fcm_pkg::IDX_W-1:0]   first_r, blk_r, blk_nxt;
  logic [fcm_pkg::BYTES_W-1:0] cur_r, len_r, fp_r;
  logic [fcm_pkg::BYTES_W-1:0] size_r, size_nxt, ptr_r, ptr_nxt;
  logic [fcm_pkg::LINK_W-1:0]  e_r, e_nxt, rdata_r;
  logic [fcm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, oldn_r, newn_r;
  logic [fcm_pkg::K_W-1:0]     k_r, k_nxt, steps_r, steps_nxt, lim;
  logic [1:0]                  status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  fcm_pkg::out_item_t          out_data_r;

  logic                        mem_we, mem_re;
  logic [fcm_pkg::IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [fcm_pkg::LINK_W-1:0]  mem_wdata;
  logic                        fin_part;
  logic [fcm_pkg::BYTES_W-1:0] fin_size, fin_ptr, cnt_bytes;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign lim = (biu_r > fcm_pkg::ENTRIES_K) ? fcm_pkg::ENTRIES_K : biu_r;

  assign st.mode        = mode_r;
  assign st.len_gt_cur  = len_r > cur_r;
  assign st.scan_end    = k_r >= lim;
  assign st.is_free     = rdata_r == fcm_pkg::MARK_FREE;
  assign st.rd_mark     = rdata_r[fcm_pkg::LINK_W-1];
  assign st.cnt_lt_new  = cnt_r < newn_r;
  assign st.cnt_lt_old  = cnt_r < oldn_r;
  assign st.e_mark      = e_r[fcm_pkg::LINK_W-1];
  assign st.follow_done = k_r == steps_r;
  assign st.free_lim    = k_r == fcm_pkg::ENTRIES_K;
  assign st.out_free    = !out_valid_r || out_ready;
  assign st.clr_done    = &k_r[fcm_pkg::IDX_W-1:0];

  assign cnt_bytes = fcm_pkg::BYTES_W'(cnt_r) << fcm_pkg::BLK_SH;
  assign fin_part  = cnt_r < newn_r;
  assign fin_size  = fin_part ? cnt_bytes : len_r;
  assign fin_ptr   = (fp_r < fin_size) ? fp_r : fin_size;

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = blk_r;
    mem_raddr = blk_r;
    mem_wdata = fcm_pkg::MARK_END;
    blk_nxt = blk_r;
    e_nxt = e_r;
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    steps_nxt = steps_r;
    status_nxt = status_r;
    size_nxt = size_r;
    ptr_nxt = ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (op)
      fcm_pkg::OP_CLR: begin
        mem_we = 1'b1;
        mem_waddr = k_r[fcm_pkg::IDX_W-1:0];
        mem_wdata = fcm_pkg::MARK_FREE;
        k_nxt = k_r + 13'd1;
      end
      fcm_pkg::OP_LOAD: begin
        blk_nxt = in_data.start_block;
        cnt_nxt = 14'd1;
        k_nxt = '0;
        status_nxt = fcm_pkg::ST_OK;
        size_nxt = '0;
        ptr_nxt = '0;
      end
      fcm_pkg::OP_SCAN_RD: begin
        mem_re = 1'b1;
        mem_raddr = k_r[fcm_pkg::IDX_W-1:0];
      end
      fcm_pkg::OP_SCAN_NX: k_nxt = k_r + 13'd1;
      fcm_pkg::OP_CREATE_OK: begin
        mem_we = 1'b1;
        mem_waddr = k_r[fcm_pkg::IDX_W-1:0];
        blk_nxt = k_r[fcm_pkg::IDX_W-1:0];
      end
      fcm_pkg::OP_CREATE_FAIL: begin
        status_nxt = fcm_pkg::ST_PARTIAL;
        blk_nxt = '0;
      end
      fcm_pkg::OP_RD_BLK: mem_re = 1'b1;
      fcm_pkg::OP_FR_STEP: begin
        mem_we = 1'b1;
        mem_wdata = fcm_pkg::MARK_FREE;
        blk_nxt = rdata_r[fcm_pkg::IDX_W-1:0];
        k_nxt = k_r + 13'd1;
      end
      fcm_pkg::OP_ADV: begin
        blk_nxt = rdata_r[fcm_pkg::IDX_W-1:0];
        cnt_nxt = cnt_r + 14'd1;
      end
      // nothing is freed during a grow, so each search resumes past the last block taken
      fcm_pkg::OP_G_MARK: mem_we = 1'b1;
      fcm_pkg::OP_G_LINK: begin
        mem_we = 1'b1;
        mem_wdata = {1'b0, k_r[fcm_pkg::IDX_W-1:0]};
        blk_nxt = k_r[fcm_pkg::IDX_W-1:0];
      end
      fcm_pkg::OP_G_NEW: begin
        mem_we = 1'b1;
        cnt_nxt = cnt_r + 14'd1;
        k_nxt = k_r + 13'd1;
      end
      fcm_pkg::OP_WR_END: mem_we = 1'b1;
      fcm_pkg::OP_S_LAST_CHK: begin
        mem_we = 1'b1;
        e_nxt = rdata_r;
      end
      fcm_pkg::OP_RD_E: begin
        mem_re = 1'b1;
        mem_raddr = e_r[fcm_pkg::IDX_W-1:0];
      end
      fcm_pkg::OP_SF_STEP: begin
        mem_we = 1'b1;
        mem_waddr = e_r[fcm_pkg::IDX_W-1:0];
        mem_wdata = fcm_pkg::MARK_FREE;
        e_nxt = rdata_r;
        cnt_nxt = cnt_r + 14'd1;
      end
      fcm_pkg::OP_SF_DONE: cnt_nxt = newn_r;
      fcm_pkg::OP_FIN: begin
        if (fin_part) status_nxt = fcm_pkg::ST_PARTIAL;
        size_nxt = fin_size;
        ptr_nxt = fin_ptr;
        steps_nxt = fcm_pkg::K_W'(fin_ptr >> fcm_pkg::BLK_SH);
        blk_nxt = first_r;
        k_nxt = '0;
      end
      fcm_pkg::OP_WALK_INIT: begin
        size_nxt = cur_r;
        k_nxt = '0;
        steps_nxt = fcm_pkg::K_W'(len_r >> fcm_pkg::BLK_SH);
        if (len_r > cur_r) begin
          status_nxt = fcm_pkg::ST_BEYOND;
          blk_nxt = '0;
          ptr_nxt = '0;
        end else begin
          blk_nxt = first_r;
          ptr_nxt = len_r;
        end
      end
      fcm_pkg::OP_FO_STEP: begin
        blk_nxt = rdata_r[fcm_pkg::IDX_W-1:0];
        k_nxt = k_r + 13'd1;
      end
      fcm_pkg::OP_OUT: out_valid_nxt = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= fcm_pkg::BIU_RESET;
      k_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) biu_r <= cfg_data;
      k_r <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    e_r <= e_nxt;
    cnt_r <= cnt_nxt;
    steps_r <= steps_nxt;
    status_r <= status_nxt;
    size_r <= size_nxt;
    ptr_r <= ptr_nxt;
    if (op == fcm_pkg::OP_LOAD) begin
      mode_r <= in_data.mode;
      first_r <= in_data.start_block;
      cur_r <= in_data.current_size;
      len_r <= in_data.length_bytes;
      fp_r <= in_data.file_pointer;
      oldn_r <= fcm_pkg::chain_blocks(in_data.current_size);
      newn_r <= fcm_pkg::chain_blocks(in_data.length_bytes);
    end
    if (op == fcm_pkg::OP_OUT) begin
      out_data_r.status <= status_r;
      out_data_r.block_index <= (mode_r == fcm_pkg::MODE_FREE) ? '0 : blk_r;
      out_data_r.size_bytes <= size_r;
      out_data_r.pointer_bytes <= ptr_r;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    op == fcm_pkg::OP_OUT |-> !out_valid_r || out_ready)
    else $error("result register overwritten");
  a_out_shows: assert property (@(posedge clk) disable iff (!rst_n)
    op == fcm_pkg::OP_OUT |=> out_valid_r)
    else $error("result not presented");
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table read and write in one cycle");
`endif

endmodule
`default_nettype wire

// ----- rtl/fcm_ctrl.sv -----
// Controller: sequences table clear, search, free, resize and walk.
// Drives fcm_datapath through fcm_pkg::dp_op_t; depends on fcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcm_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          in_mode,
  input  fcm_pkg::dp_status_t st,
  output fcm_pkg::dp_op_t     op
);

  typedef enum logic [21:0] {
    S_CLR    = 22'd1 << 0,  S_IDLE   = 22'd1 << 1,  S_DISP  = 22'd1 << 2,
    S_SCAN   = 22'd1 << 3,  S_SCHK   = 22'd1 << 4,  S_FR_RD = 22'd1 << 5,
    S_FR_CHK = 22'd1 << 6,  S_G_RD   = 22'd1 << 7,  S_G_CHK = 22'd1 << 8,
    S_G_NEW  = 22'd1 << 9,  S_G_END  = 22'd1 << 10, S_S_RD  = 22'd1 << 11,
    S_S_CHK  = 22'd1 << 12, S_S_LAST = 22'd1 << 13, S_S_LCHK = 22'd1 << 14,
    S_SF     = 22'd1 << 15, S_SF_CHK = 22'd1 << 16, S_FIN   = 22'd1 << 17,
    S_WALK   = 22'd1 << 18, S_FO_RD  = 22'd1 << 19, S_FO_CHK = 22'd1 << 20,
    S_OUT    = 22'd1 << 21
  } state_t;

  state_t state_r, state_nxt;
  logic   is_create;

  assign is_create = st.mode == fcm_pkg::MODE_CREATE;

  always_comb begin
    state_nxt = state_r;
    op = fcm_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLR: begin
        op = fcm_pkg::OP_CLR;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = fcm_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.mode)
          fcm_pkg::MODE_CREATE: state_nxt = S_SCAN;
          fcm_pkg::MODE_FREE:   state_nxt = S_FR_RD;
          fcm_pkg::MODE_RESIZE: state_nxt = st.len_gt_cur ? S_G_RD : S_S_RD;
          default:              state_nxt = S_WALK;
        endcase
      end
      S_SCAN: begin
        if (st.scan_end) begin
          if (is_create) begin
            op = fcm_pkg::OP_CREATE_FAIL;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_G_END;
          end
        end else begin
          op = fcm_pkg::OP_SCAN_RD;
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (st.is_free) begin
          if (is_create) begin
            op = fcm_pkg::OP_CREATE_OK;
            state_nxt = S_OUT;
          end else begin
            op = fcm_pkg::OP_G_LINK;
            state_nxt = S_G_NEW;
          end
        end else begin
          op = fcm_pkg::OP_SCAN_NX;
          state_nxt = S_SCAN;
        end
      end
      S_FR_RD: begin
        if (st.free_lim) begin
          state_nxt = S_OUT;
        end else begin
          op = fcm_pkg::OP_RD_BLK;
          state_nxt = S_FR_CHK;
        end
      end
      S_FR_CHK: begin
        if (st.is_free) begin
          state_nxt = S_OUT;
        end else begin
          op = fcm_pkg::OP_FR_STEP;
          state_nxt = st.rd_mark ? S_OUT : S_FR_RD;
        end
      end
      S_G_RD: begin
        if (!st.cnt_lt_new) begin
          state_nxt = S_G_END;
        end else begin
          op = fcm_pkg::OP_RD_BLK;
          state_nxt = S_G_CHK;
        end
      end
      S_G_CHK: begin
        if (st.cnt_lt_old && !st.rd_mark) begin
          op = fcm_pkg::OP_ADV;
          state_nxt = S_G_RD;
        end else begin
          op = fcm_pkg::OP_G_MARK;
          state_nxt = S_SCAN;
        end
      end
      S_G_NEW: begin
        op = fcm_pkg::OP_G_NEW;
        state_nxt = S_G_RD;
      end
      S_G_END: begin
        op = fcm_pkg::OP_WR_END;
        state_nxt = S_FIN;
      end
      S_S_RD: begin
        if (!st.cnt_lt_new) begin
          state_nxt = S_S_LAST;
        end else begin
          op = fcm_pkg::OP_RD_BLK;
          state_nxt = S_S_CHK;
        end
      end
      S_S_CHK: begin
        if (st.rd_mark) begin
          state_nxt = S_S_LAST;
        end else begin
          op = fcm_pkg::OP_ADV;
          state_nxt = S_S_RD;
        end
      end
      S_S_LAST: begin
        op = fcm_pkg::OP_RD_BLK;
        state_nxt = S_S_LCHK;
      end
      S_S_LCHK: begin
        op = fcm_pkg::OP_S_LAST_CHK;
        state_nxt = st.cnt_lt_new ? S_FIN : S_SF;
      end
      S_SF: begin
        if (st.cnt_lt_old && !st.e_mark) begin
          op = fcm_pkg::OP_RD_E;
          state_nxt = S_SF_CHK;
        end else begin
          op = fcm_pkg::OP_SF_DONE;
          state_nxt = S_FIN;
        end
      end
      S_SF_CHK: begin
        op = fcm_pkg::OP_SF_STEP;
        state_nxt = S_SF;
      end
      S_FIN: begin
        op = fcm_pkg::OP_FIN;
        state_nxt = S_FO_RD;
      end
      S_WALK: begin
        op = fcm_pkg::OP_WALK_INIT;
        state_nxt = st.len_gt_cur ? S_OUT : S_FO_RD;
      end
      S_FO_RD: begin
        if (st.follow_done) begin
          state_nxt = S_OUT;
        end else begin
          op = fcm_pkg::OP_RD_BLK;
          state_nxt = S_FO_CHK;
        end
      end
      S_FO_CHK: begin
        if (st.rd_mark) begin
          state_nxt = S_OUT;
        end else begin
          op = fcm_pkg::OP_FO_STEP;
          state_nxt = S_FO_RD;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          op = fcm_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  // in_mode is sampled by the datapath; seen here only for the load check
`ifndef SYNTHESIS
  a_load_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DISP && st.mode == $past(in_mode)))
    else $error("request not loaded");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ready)
    else $error("request taken during clear");
  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && st.out_free) |=> state_r == S_IDLE)
    else $error("result stage stuck");
`endif

endmodule
`default_nettype wire

// ----- rtl/fat_chain_manager.sv -----
// Top level of the file allocation table chain manager.
// Instantiates fcm_ctrl and fcm_datapath; depends on fcm_pkg.
//
// Usage: requests enter on in_valid/in_ready with an fcm_pkg::in_item_t
// (mode, start_block, sizes); one result per request leaves on
// out_valid/out_ready as an fcm_pkg::out_item_t. cfg_valid/cfg_ready writes
// blocks_in_use (always ready; write only while idle).
// One request at a time. Each table access is a registered read, then a
// check. Create scans from entry 0 up to the first free one, free and
// walk follow the chain, resize walks the chain and its free searches
// together scan the table at most once.
// After reset all 4096 table entries are cleared, one entry a cycle;
// in_ready stays low during that pass. A result waits in the output
// register while the receiver stalls; the next request is taken meanwhile
// and is held at its end until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module fat_chain_manager (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  fcm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output fcm_pkg::out_item_t out_data,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [12:0]        cfg_data
);

  fcm_pkg::dp_op_t     op;
  fcm_pkg::dp_status_t st;

  fcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_data.mode),
    .st       (st),
    .op       (op)
  );

  fcm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .st        (st)
  );

endmodule
`default_nettype wire

// ----- tb/sv/fat_chain_checker.sv -----
// Checker for the chain manager: watches the request, result and register channels.
// Keeps its own link table, predicts each result and compares; depends on fcm_pkg.
`timescale 1ns / 1ps
module fat_chain_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  fcm_pkg::in_item_t  in_data,
  input  wire                out_valid,
  input  wire                out_ready,
  input  fcm_pkg::out_item_t out_data,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  wire  [12:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int BB = 4096;

  logic [12:0] links [fcm_pkg::ENTRIES];
  logic [12:0] search_limit;
  fcm_pkg::out_item_t results_due [$];

  function automatic int unsigned blocks_for(int unsigned b);
    if (b == 0) return 1;
    return (b - 1) / BB + 1;
  endfunction

  function automatic int unsigned lowest_free();
    int unsigned lim;
    lim = (32'(search_limit) > fcm_pkg::ENTRIES) ? fcm_pkg::ENTRIES : 32'(search_limit);
    for (int unsigned k = 0; k < lim; k++)
      if (links[k] == fcm_pkg::MARK_FREE) return k;
    return fcm_pkg::ENTRIES;
  endfunction

  function automatic int unsigned chase(int unsigned blk, int unsigned steps);
    for (int unsigned k = 0; k < steps; k++) begin
      if (blk >= fcm_pkg::ENTRIES || links[blk] >= fcm_pkg::ENTRIES) break;
      blk = 32'(links[blk]);
    end
    return blk;
  endfunction

  function automatic void release_chain(int unsigned blk);
    logic [12:0] e;
    for (int k = 0; k < fcm_pkg::ENTRIES; k++) begin
      if (blk >= fcm_pkg::ENTRIES) break;
      e = links[blk];
      if (e == fcm_pkg::MARK_FREE) break;
      links[blk] = fcm_pkg::MARK_FREE;
      if (e >= fcm_pkg::ENTRIES) break;
      blk = 32'(e);
    end
  endfunction

  function automatic fcm_pkg::out_item_t resize_chain(fcm_pkg::in_item_t r);
    fcm_pkg::out_item_t o;
    int unsigned oldn, newn, cnt, blk, e, f, nx, size, ptr;
    o = '0;
    oldn = blocks_for(32'(r.current_size));
    newn = blocks_for(32'(r.length_bytes));
    cnt = 1;
    blk = 32'(r.start_block);
    size = 32'(r.length_bytes);
    if (r.length_bytes > r.current_size) begin
      while (cnt < newn) begin
        e = 32'(links[blk]);
        if (cnt < oldn && e < fcm_pkg::ENTRIES) begin
          blk = e;
          cnt++;
        end else begin
          links[blk] = fcm_pkg::MARK_END;
          f = lowest_free();
          if (f >= fcm_pkg::ENTRIES) break;
          links[blk] = 13'(f);
          links[f] = fcm_pkg::MARK_END;
          blk = f;
          cnt++;
        end
      end
      links[blk] = fcm_pkg::MARK_END;
    end else begin
      while (cnt < newn) begin
        e = 32'(links[blk]);
        if (e >= fcm_pkg::ENTRIES) break;
        blk = e;
        cnt++;
      end
      e = 32'(links[blk]);
      links[blk] = fcm_pkg::MARK_END;
      if (cnt == newn) begin
        while (cnt < oldn && e < fcm_pkg::ENTRIES) begin
          nx = 32'(links[e]);
          links[e] = fcm_pkg::MARK_FREE;
          e = nx;
          cnt++;
        end
        cnt = newn;
      end
    end
    if (cnt < newn) begin
      o.status = fcm_pkg::ST_PARTIAL;
      size = cnt * BB;
    end
    ptr = (32'(r.file_pointer) < size) ? 32'(r.file_pointer) : size;
    o.block_index = 12'(chase(32'(r.start_block), ptr / BB));
    o.size_bytes = 25'(size);
    o.pointer_bytes = 25'(ptr);
    return o;
  endfunction

  function automatic fcm_pkg::out_item_t chain_request(fcm_pkg::in_item_t r);
    fcm_pkg::out_item_t o;
    int unsigned f;
    o = '0;
    case (r.mode)
      fcm_pkg::MODE_CREATE: begin
        f = lowest_free();
        if (f >= fcm_pkg::ENTRIES) o.status = fcm_pkg::ST_PARTIAL;
        else begin
          links[f] = fcm_pkg::MARK_END;
          o.block_index = 12'(f);
        end
      end
      fcm_pkg::MODE_FREE: release_chain(32'(r.start_block));
      fcm_pkg::MODE_RESIZE: begin
        if (r.start_block < fcm_pkg::ENTRIES) o = resize_chain(r);
        else o.status = fcm_pkg::ST_PARTIAL;
      end
      default: begin
        o.size_bytes = r.current_size;
        if (r.length_bytes > r.current_size) o.status = fcm_pkg::ST_BEYOND;
        else begin
          o.block_index = 12'(chase(32'(r.start_block), 32'(r.length_bytes) / BB));
          o.pointer_bytes = r.length_bytes;
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    fcm_pkg::out_item_t want;
    if (!rst_n) begin
      for (int k = 0; k < fcm_pkg::ENTRIES; k++) links[k] = fcm_pkg::MARK_FREE;
      search_limit = fcm_pkg::BIU_RESET;
      fail_count = 0;
      results_due.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) search_limit = cfg_data;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none due: %p", $time, out_data);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) results_due.push_back(chain_request(in_data));
      pending = results_due.size();
    end
  end
endmodule

// ----- tb/sv/fat_chain_manager_tb.sv -----
// Top of the chain manager testbench: clock, reset, stimulus and verdict.
// Instantiates fat_chain_manager and fat_chain_checker; depends on fcm_pkg.
`timescale 1ns / 1ps
module fat_chain_manager_tb;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  fcm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  fcm_pkg::out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [12:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycle_count = 0;
  bit calm = 0;
  int live_chains [$];

  always #2 clk = ~clk;

  fat_chain_manager dut (.*);
  fat_chain_checker chk (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 300000000) begin
      $display("fat_chain_manager_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 18);

  task automatic send(fcm_pkg::in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 18) @(negedge clk);
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_limit(logic [12:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic fcm_pkg::in_item_t req(logic [1:0] m, int fb, int cur, int len, int fp);
    fcm_pkg::in_item_t it;
    it.mode = m;
    it.start_block = 12'(fb);
    it.current_size = 25'(cur);
    it.length_bytes = 25'(len);
    it.file_pointer = 25'(fp);
    return it;
  endfunction

  function automatic int rand_len();
    case ($urandom_range(9))
      0: return $urandom_range(25'h1000000);
      1: return $urandom & 25'h1FFFFFF;
      2: return $urandom_range(3) * 4096 + $urandom_range(2) - 1;
      default: return $urandom_range(40000);
    endcase
  endfunction

  task automatic random_phase(int n);
    fcm_pkg::in_item_t it;
    int fb, cur, pick;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2 && i < n / 2 + 60);
      if (i == n / 3) drain();
      pick = $urandom_range(99);
      fb = live_chains.size() ? live_chains[$urandom_range(live_chains.size() - 1)]
                              : $urandom_range(4095);
      if (pick < 10) fb = $urandom_range(4095);
      cur = rand_len();
      case ($urandom_range(9))
        0, 1: it = req(fcm_pkg::MODE_CREATE, $urandom_range(4095), $urandom & 25'h1FFFFFF,
                       $urandom & 25'h1FFFFFF, $urandom & 25'h1FFFFFF);
        2: it = req(fcm_pkg::MODE_FREE, fb, cur, rand_len(), rand_len());
        3, 4, 5: it = req(fcm_pkg::MODE_RESIZE, fb, cur, rand_len(), rand_len());
        default: it = req(fcm_pkg::MODE_WALK, fb, cur, rand_len(), 0);
      endcase
      if (it.mode == fcm_pkg::MODE_CREATE && live_chains.size() < 40) live_chains.push_back(0);
      send(it);
      if (it.mode == fcm_pkg::MODE_CREATE) begin
        drain();
        if (pending == 0 && out_data.status == fcm_pkg::ST_OK)
          live_chains[$] = 32'(out_data.block_index);
      end
    end
    calm = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    write_limit(13'd4096);
    send(req(fcm_pkg::MODE_CREATE, 0, 0, 0, 0));
    send(req(fcm_pkg::MODE_WALK, 0, 0, 0, 0));
    send(req(fcm_pkg::MODE_RESIZE, 0, 0, 12288, 25'h1FFFFFF));
    send(req(fcm_pkg::MODE_WALK, 0, 12288, 12288, 0));
    send(req(fcm_pkg::MODE_WALK, 0, 12288, 12289, 0));
    send(req(fcm_pkg::MODE_RESIZE, 0, 12288, 4097, 5000));
    send(req(fcm_pkg::MODE_RESIZE, 0, 8192, 0, 0));
    send(req(fcm_pkg::MODE_FREE, 0, 0, 0, 0));
    send(req(fcm_pkg::MODE_FREE, 0, 0, 0, 0));
    send(req(fcm_pkg::MODE_WALK, 4095, 25'h1FFFFFF, 25'h1000000, 0));
    send(req(fcm_pkg::MODE_RESIZE, 4095, 0, 25'h1FFFFFF, 25'h1FFFFFF));
    send(req(fcm_pkg::MODE_FREE, 4095, 0, 0, 0));
    write_limit(13'd1);
    send(req(fcm_pkg::MODE_CREATE, 0, 0, 0, 0));
    send(req(fcm_pkg::MODE_CREATE, 0, 0, 0, 0));
    send(req(fcm_pkg::MODE_RESIZE, 0, 0, 9000, 9000));
    send(req(fcm_pkg::MODE_FREE, 0, 0, 0, 0));
    write_limit(13'd4);
    send(req(fcm_pkg::MODE_CREATE, 0, 0, 0, 0));
    send(req(fcm_pkg::MODE_RESIZE, 0, 4096, 25'h1000000, 100000));
    send(req(fcm_pkg::MODE_FREE, 0, 0, 0, 0));
    write_limit(13'h1FFF);
    random_phase(260);
    write_limit(13'd6);
    random_phase(260);
    write_limit(13'd1);
    random_phase(120);
    write_limit(13'd4096);
    random_phase(400);
    drain();
    if (fail_count == 0) begin
      $display("fat_chain_manager_tb OK");
    end else begin
      $display("fat_chain_manager_tb NOT OK");
    end
    $finish;
  end
endmodule
